>>> hw/rtl/lnsa_pkg.sv
// lnsa_pkg: shared constants, request codes and beat/record types for the
// live note slot allocator. No dependencies; every other RTL file imports it.
package lnsa_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int IDX_W      = $clog2(SLOT_COUNT);
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int KEY_W      = 19;
	localparam int NOTE_W     = 7;
	localparam int TIME_W     = 32;

	typedef logic [2:0]        req_code_t;
	typedef logic [IDX_W-1:0]  slot_idx_t;
	typedef logic [CNT_W-1:0]  slot_cnt_t;
	typedef logic [TIME_W-1:0] time_t;
	typedef logic [KEY_W-1:0]  key_t;

	localparam req_code_t REQ_NOTE_ON  = 3'd0;
	localparam req_code_t REQ_NOTE_OFF = 3'd1;
	localparam req_code_t REQ_ALL_OFF  = 3'd2;
	localparam req_code_t REQ_CHAN_OFF = 3'd3;
	localparam req_code_t REQ_EXPIRE   = 3'd4;
	localparam req_code_t REQ_CLEAR    = 3'd5;

	localparam time_t HOLD_RESET = 32'd1000;

	typedef struct packed {
		req_code_t  req_type;
		logic [7:0] port_number;
		logic [3:0] channel_number;
		logic [6:0] note_number;
		time_t      now_ms;
	} req_t;

	typedef struct packed {
		slot_idx_t slot_index;
		logic      hit;
		logic      stolen;
		slot_cnt_t changed_count;
		slot_cnt_t active_count;
	} rsp_t;

	// one table entry as stored in the slot memory (active bits live in flops)
	typedef struct packed {
		key_t  key;
		time_t start;
		time_t rel;
	} slot_ent_t;

	typedef struct packed {
		logic      en;
		slot_idx_t addr;
		slot_ent_t data;
	} mem_wr_t;

	typedef struct packed {
		logic      en;
		slot_idx_t addr;
	} mem_rd_t;

endpackage

>>> hw/rtl/lnsa_req_if.sv
// lnsa_req_if: valid/ready request channel carrying one note event per beat.
// Depends on lnsa_pkg.
interface lnsa_req_if;
	import lnsa_pkg::*;

	logic       valid;
	logic       ready;
	req_code_t  req_type;
	logic [7:0] port_number;
	logic [3:0] channel_number;
	logic [6:0] note_number;
	time_t      now_ms;

	modport source (output valid, req_type, port_number, channel_number, note_number,
		now_ms, input ready);
	modport sink (input valid, req_type, port_number, channel_number, note_number,
		now_ms, output ready);
endinterface

>>> hw/rtl/lnsa_rsp_if.sv
// lnsa_rsp_if: valid/ready result channel, one result beat per request.
// Depends on lnsa_pkg.
interface lnsa_rsp_if;
	import lnsa_pkg::*;

	logic      valid;
	logic      ready;
	slot_idx_t slot_index;
	logic      hit;
	logic      stolen;
	slot_cnt_t changed_count;
	slot_cnt_t active_count;

	modport source (output valid, slot_index, hit, stolen, changed_count, active_count,
		input ready);
	modport sink (input valid, slot_index, hit, stolen, changed_count, active_count,
		output ready);
endinterface

>>> hw/rtl/lnsa_slot_mem.sv
// lnsa_slot_mem: slot table storage (key, start, release), one write and one
// registered read port. Depends on lnsa_pkg.
module lnsa_slot_mem (
	input  logic                clk,
	input  lnsa_pkg::mem_wr_t   wr,
	input  lnsa_pkg::mem_rd_t   rd,
	output lnsa_pkg::slot_ent_t rd_data
);
	import lnsa_pkg::*;

	slot_ent_t mem [SLOT_COUNT];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end
endmodule

>>> hw/rtl/lnsa_ctrl.sv
// lnsa_ctrl: request sequencer. Scans the slot memory one entry per cycle,
// holds active bits, active count and hold_duration. Depends on lnsa_pkg.
module lnsa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  lnsa_pkg::time_t     cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  lnsa_pkg::req_t      in_req,
	output logic                res_valid,
	input  logic                res_ready,
	output lnsa_pkg::rsp_t      res,
	output lnsa_pkg::mem_wr_t   mem_wr,
	output lnsa_pkg::mem_rd_t   mem_rd,
	input  lnsa_pkg::slot_ent_t mem_rd_data
);
	import lnsa_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_OLDEST = 3'd2;
	localparam logic [2:0] ST_PLACE  = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	localparam logic [IDX_W:0] RD_END  = (IDX_W+1)'(SLOT_COUNT);
	localparam slot_idx_t      IDX_LAST = IDX_W'(SLOT_COUNT - 1);

	logic [2:0]            st_q;
	logic [IDX_W:0]        rd_cnt_q;
	logic                  chk_vld_s1;
	slot_idx_t             chk_addr_s1;
	logic [SLOT_COUNT-1:0] act_q;
	slot_cnt_t             act_cnt_q;
	time_t                 hold_q;
	req_code_t             req_q;
	key_t                  key_q;
	time_t                 now_q;
	slot_idx_t             pick_q;
	time_t                 best_t_q;
	slot_idx_t             idx_q;
	logic                  hit_q;
	logic                  stolen_q;
	slot_cnt_t             chg_q;

	logic  act_cur, expired, sounding, match_off, match_all, free_hit, older;
	logic  chk_last, stop;
	time_t age;

	assign act_cur  = act_q[chk_addr_s1];
	assign age      = now_q - mem_rd_data.rel;
	assign expired  = act_cur && (mem_rd_data.rel != '0) && (age > hold_q);
	assign sounding = act_cur && (mem_rd_data.rel == '0);
	assign match_off = sounding && (mem_rd_data.key == key_q);
	// channel match compares port and channel, ignoring the note bits
	assign match_all = sounding && ((req_q == REQ_ALL_OFF) ||
		(mem_rd_data.key[KEY_W-1:NOTE_W] == key_q[KEY_W-1:NOTE_W]));
	assign free_hit = !act_cur || expired;
	assign older    = (chk_addr_s1 == '0) || (mem_rd_data.start < best_t_q);
	assign chk_last = chk_addr_s1 == IDX_LAST;
	assign stop     = (st_q == ST_SCAN) && chk_vld_s1 &&
		(((req_q == REQ_NOTE_ON) && free_hit) || ((req_q == REQ_NOTE_OFF) && match_off));

	assign in_ready  = st_q == ST_IDLE;
	assign res_valid = st_q == ST_DONE;
	assign res = '{slot_index: idx_q, hit: hit_q, stolen: stolen_q,
		changed_count: chg_q, active_count: act_cnt_q};

	always_comb begin
		mem_rd.en   = ((st_q == ST_SCAN) || (st_q == ST_OLDEST)) && (rd_cnt_q != RD_END);
		mem_rd.addr = rd_cnt_q[IDX_W-1:0];
		mem_wr.en   = 1'b0;
		mem_wr.addr = chk_addr_s1;
		mem_wr.data = '{key: mem_rd_data.key, start: mem_rd_data.start, rel: now_q};
		if (st_q == ST_PLACE) begin
			mem_wr.en   = 1'b1;
			mem_wr.addr = pick_q;
			mem_wr.data = '{key: key_q, start: now_q, rel: '0};
		end else if ((st_q == ST_SCAN) && chk_vld_s1) begin
			if ((req_q == REQ_NOTE_OFF) && match_off) begin
				mem_wr.en = 1'b1;
			end else if (((req_q == REQ_ALL_OFF) || (req_q == REQ_CHAN_OFF)) && match_all) begin
				mem_wr.en = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_RESET;
		end else if (cfg_wr_en) begin
			hold_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			rd_cnt_q    <= '0;
			chk_vld_s1  <= 1'b0;
			chk_addr_s1 <= '0;
			act_q       <= '0;
			act_cnt_q   <= '0;
			req_q       <= REQ_NOTE_ON;
			key_q       <= '0;
			now_q       <= '0;
			pick_q      <= '0;
			best_t_q    <= '0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			stolen_q    <= 1'b0;
			chg_q       <= '0;
		end else begin
			chk_vld_s1  <= mem_rd.en && !stop;
			chk_addr_s1 <= mem_rd.addr;
			if (mem_rd.en) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q    <= in_req.req_type;
						key_q    <= {in_req.port_number, in_req.channel_number,
							in_req.note_number};
						now_q    <= in_req.now_ms;
						rd_cnt_q <= '0;
						idx_q    <= '0;
						hit_q    <= 1'b0;
						stolen_q <= 1'b0;
						chg_q    <= '0;
						case (in_req.req_type)
							REQ_NOTE_ON, REQ_NOTE_OFF, REQ_ALL_OFF, REQ_CHAN_OFF,
							REQ_EXPIRE: begin
								st_q <= ST_SCAN;
							end
							REQ_CLEAR: begin
								chg_q     <= act_cnt_q;
								act_q     <= '0;
								act_cnt_q <= '0;
								st_q      <= ST_DONE;
							end
							default: begin
								st_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (chk_vld_s1) begin
						case (req_q)
							REQ_NOTE_ON: begin
								if (free_hit) begin
									pick_q <= chk_addr_s1;
									chg_q  <= slot_cnt_t'(act_cur);
									st_q   <= ST_PLACE;
								end else if (chk_last) begin
									rd_cnt_q <= '0;
									st_q     <= ST_OLDEST;
								end
							end
							REQ_NOTE_OFF: begin
								if (match_off) begin
									idx_q <= chk_addr_s1;
									hit_q <= 1'b1;
									chg_q <= slot_cnt_t'(1);
									st_q  <= ST_DONE;
								end else if (chk_last) begin
									st_q <= ST_DONE;
								end
							end
							REQ_ALL_OFF, REQ_CHAN_OFF: begin
								if (match_all) begin
									chg_q <= chg_q + slot_cnt_t'(1);
								end
								if (chk_last) begin
									st_q <= ST_DONE;
								end
							end
							REQ_EXPIRE: begin
								if (expired) begin
									act_q[chk_addr_s1] <= 1'b0;
									act_cnt_q <= act_cnt_q - slot_cnt_t'(1);
									chg_q     <= chg_q + slot_cnt_t'(1);
								end
								if (chk_last) begin
									st_q <= ST_DONE;
								end
							end
							default: begin
								st_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_OLDEST: begin
					// every slot is active here: plain minimum of start times
					if (chk_vld_s1) begin
						if (older) begin
							best_t_q <= mem_rd_data.start;
							pick_q   <= chk_addr_s1;
						end
						if (chk_last) begin
							stolen_q <= 1'b1;
							chg_q    <= slot_cnt_t'(1);
							st_q     <= ST_PLACE;
						end
					end
				end
				ST_PLACE: begin
					act_q[pick_q] <= 1'b1;
					act_cnt_q     <= act_cnt_q + slot_cnt_t'(!act_q[pick_q]);
					idx_q         <= pick_q;
					hit_q         <= 1'b1;
					st_q          <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

>>> hw/rtl/live_note_slot_allocator_top.sv
// live_note_slot_allocator_top: top level, ties the sequencer to the slot memory
// and registers result beats. Depends on lnsa_pkg, lnsa_req_if, lnsa_rsp_if,
// lnsa_slot_mem and lnsa_ctrl.
//
// Usage
//   req: one beat per note event (note on/off, all off, channel off, expire
//        sweep, clear). rsp: exactly one result beat per request, in order.
//   cfg_wr_en/cfg_wr_data load hold_duration (ms); write only while idle.
//   Note on makes a first-fit scan of the 64 slots, then, with no free or
//   expired slot, a second scan for the oldest start time; note off, all
//   off, channel off and expire sweep make at most one scan; clear and
//   unused codes go straight to the result. One request is in work at a
//   time; the slot memory is read one entry per cycle through its single
//   registered read port.
//   Active bits sit in flops, so reset empties the table at once; no clearing
//   pass. hold_duration resets to 1000.
//   A result waits in the output register while rsp stalls; one more request
//   can be accepted and worked on meanwhile, and it holds its result until
//   the register frees.
module live_note_slot_allocator_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  lnsa_pkg::time_t cfg_wr_data,
	lnsa_req_if.sink        req,
	lnsa_rsp_if.source      rsp
);
	import lnsa_pkg::*;

	req_t      in_req;
	rsp_t      res;
	logic      res_valid;
	logic      res_ready;
	mem_wr_t   mem_wr;
	mem_rd_t   mem_rd;
	slot_ent_t mem_rd_data;
	rsp_t      out_q;
	logic      out_vld_q;

	assign in_req = '{req_type: req.req_type, port_number: req.port_number,
		channel_number: req.channel_number, note_number: req.note_number,
		now_ms: req.now_ms};

	lnsa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (req.valid),
		.in_ready    (req.ready),
		.in_req      (in_req),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_wr      (mem_wr),
		.mem_rd      (mem_rd),
		.mem_rd_data (mem_rd_data)
	);

	lnsa_slot_mem u_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.rd      (mem_rd),
		.rd_data (mem_rd_data)
	);

	// output register: loads when empty or being drained this cycle
	assign res_ready = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else if (res_valid && res_ready) begin
			out_vld_q <= 1'b1;
			out_q     <= res;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.slot_index    = out_q.slot_index;
	assign rsp.hit           = out_q.hit;
	assign rsp.stolen        = out_q.stolen;
	assign rsp.changed_count = out_q.changed_count;
	assign rsp.active_count  = out_q.active_count;
endmodule

>>> test/tb_top.sv
// tb_top: self-checking testbench for live_note_slot_allocator_top.
// Depends on lnsa_pkg, lnsa_req_if, lnsa_rsp_if and the allocator RTL.
// The scoreboard keeps its own slot table and checks each result beat in order.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lnsa_pkg::*;

	// request codes the block treats as no-ops
	localparam req_code_t REQ_SPARE_A = 3'd6;
	localparam req_code_t REQ_SPARE_B = 3'd7;

	localparam int PHASE_ITEMS  = 350;
	localparam int DRAIN_CYCLES = 150;  // a bit over the slowest note-on latency
	localparam int LONG_HOLD    = 800;

	typedef enum {RX_OPEN, RX_CHOPPY, RX_CLOGGED} rx_mode_e;

	// Shadow copy of the slot table; predicts one result beat per request
	// and compares accepted result beats against the oldest prediction.
	class note_table_scoreboard;
		time_t hold_ms;
		bit    live [SLOT_COUNT];
		key_t  slot_key [SLOT_COUNT];
		time_t start_ms [SLOT_COUNT];
		time_t rel_ms [SLOT_COUNT];
		rsp_t  expected_q [$];
		int    errors;
		int    beats_checked;
		int    steals, reuses, off_hits, swept;

		function new();
			hold_ms = HOLD_RESET;
			wipe_all();
		endfunction

		function void wipe_slot(int i);
			live[i]     = 1'b0;
			slot_key[i] = '0;
			start_ms[i] = '0;
			rel_ms[i]   = '0;
		endfunction

		function void wipe_all();
			for (int i = 0; i < SLOT_COUNT; i++)
				wipe_slot(i);
		endfunction

		// released notes age with wrapping subtraction
		function bit has_expired(int i, time_t now);
			time_t age;
			age = now - rel_ms[i];
			return live[i] && rel_ms[i] != '0 && age > hold_ms;
		endfunction

		function rsp_t predict(req_t r);
			rsp_t res;
			key_t k;
			int   pick;
			bit   found;
			res   = '0;
			k     = {r.port_number, r.channel_number, r.note_number};
			pick  = 0;
			found = 1'b0;
			case (r.req_type)
				REQ_NOTE_ON: begin
					for (int i = 0; i < SLOT_COUNT; i++)
						if (!found && (!live[i] || has_expired(i, r.now_ms))) begin
							pick  = i;
							found = 1'b1;
						end
					if (found) begin
						res.changed_count = slot_cnt_t'(live[pick]);
						if (live[pick])
							reuses++;
					end else begin
						// table full of live notes: evict the oldest start, lowest index wins ties
						for (int i = 1; i < SLOT_COUNT; i++)
							if (start_ms[i] < start_ms[pick])
								pick = i;
						res.stolen        = 1'b1;
						res.changed_count = slot_cnt_t'(1);
						steals++;
					end
					live[pick]     = 1'b1;
					slot_key[pick] = k;
					start_ms[pick] = r.now_ms;
					rel_ms[pick]   = '0;
					res.slot_index = slot_idx_t'(pick);
					res.hit        = 1'b1;
				end
				REQ_NOTE_OFF: begin
					for (int i = 0; i < SLOT_COUNT; i++)
						if (!res.hit && live[i] && slot_key[i] == k && rel_ms[i] == '0) begin
							rel_ms[i]         = r.now_ms;
							res.slot_index    = slot_idx_t'(i);
							res.hit           = 1'b1;
							res.changed_count = slot_cnt_t'(1);
							off_hits++;
						end
				end
				REQ_ALL_OFF, REQ_CHAN_OFF: begin
					for (int i = 0; i < SLOT_COUNT; i++)
						if (live[i] && rel_ms[i] == '0 && (r.req_type == REQ_ALL_OFF ||
								slot_key[i][KEY_W-1:NOTE_W] == {r.port_number, r.channel_number})) begin
							rel_ms[i] = r.now_ms;
							res.changed_count++;
						end
				end
				REQ_EXPIRE: begin
					for (int i = 0; i < SLOT_COUNT; i++)
						if (has_expired(i, r.now_ms)) begin
							wipe_slot(i);
							res.changed_count++;
							swept++;
						end
				end
				REQ_CLEAR: begin
					for (int i = 0; i < SLOT_COUNT; i++)
						if (live[i])
							res.changed_count++;
					wipe_all();
				end
				default: ;
			endcase
			for (int i = 0; i < SLOT_COUNT; i++)
				if (live[i])
					res.active_count++;
			return res;
		endfunction

		function void log_request(req_t r);
			expected_q.push_back(predict(r));
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("MISMATCH: %s", msg);
		endfunction

		function void cmp(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got)
				flag($sformatf("beat %0d %s expected %0d got %0d", beats_checked, field, want,
					got));
		endfunction

		function void match_result(rsp_t got);
			rsp_t want;
			if (expected_q.size() == 0) begin
				flag("result beat with no request outstanding");
				return;
			end
			want = expected_q.pop_front();
			beats_checked++;
			cmp("slot_index", 32'(want.slot_index), 32'(got.slot_index));
			cmp("hit", 32'(want.hit), 32'(got.hit));
			cmp("stolen", 32'(want.stolen), 32'(got.stolen));
			cmp("changed_count", 32'(want.changed_count), 32'(got.changed_count));
			cmp("active_count", 32'(want.active_count), 32'(got.active_count));
		endfunction

		function void finish_check();
			if (expected_q.size() != 0)
				flag($sformatf("%0d result beats never arrived", expected_q.size()));
			errors += (expected_q.size() > 1) ? expected_q.size() - 1 : 0;
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n;
	logic  cfg_wr_en;
	time_t cfg_wr_data;

	lnsa_req_if req_ch ();
	lnsa_rsp_if rsp_ch ();

	live_note_slot_allocator_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req_ch),
		.rsp        (rsp_ch)
	);

	always #5 clk = ~clk;

	note_table_scoreboard sb = new();

	// sender pacing
	int    burst_left = 0;
	int    gap_left   = 0;
	bit    eager      = 1'b0;  // no gaps while set
	int    items_sent = 0;
	time_t clock_ms   = '0;    // running millisecond clock fed to now_ms

	// receiver pacing
	rx_mode_e rx_mode     = RX_OPEN;
	int       rx_seg_left = 0;
	int       rx_hold     = 0;
	bit       ask_hold    = 1'b0;

	// Receiver: segments of always-ready, choppy and mostly-stalled behavior,
	// plus one long hold-off when the stimulus asks for it.
	always @(negedge clk) begin
		if (ask_hold) begin
			rx_hold  = LONG_HOLD;
			ask_hold = 1'b0;
		end
		if (rx_hold > 0) begin
			rsp_ch.ready = 1'b0;
			rx_hold--;
		end else begin
			if (rx_seg_left == 0) begin
				rx_mode     = rx_mode_e'($urandom_range(0, 2));
				rx_seg_left = $urandom_range(10, 150);
			end
			rx_seg_left--;
			case (rx_mode)
				RX_OPEN:    rsp_ch.ready = 1'b1;
				RX_CHOPPY:  rsp_ch.ready = 1'($urandom_range(0, 1));
				RX_CLOGGED: rsp_ch.ready = ($urandom_range(0, 3) == 0);
				default:    rsp_ch.ready = 1'b1;
			endcase
		end
	end

	// Result monitor: every accepted beat goes to the scoreboard.
	always @(posedge clk) begin
		rsp_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.slot_index    = rsp_ch.slot_index;
			got.hit           = rsp_ch.hit;
			got.stolen        = rsp_ch.stolen;
			got.changed_count = rsp_ch.changed_count;
			got.active_count  = rsp_ch.active_count;
			sb.match_result(got);
		end
	end

	// Drive one request beat. Called at a falling edge, returns at the falling
	// edge after acceptance with valid still high, so back-to-back beats never
	// see valid drop.
	task automatic send_request(req_t r);
		if (!eager) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			end
			if (gap_left > 0) begin
				req_ch.valid = 1'b0;
				repeat (gap_left) @(negedge clk);
				gap_left = 0;
			end
			burst_left--;
		end
		req_ch.req_type       = r.req_type;
		req_ch.port_number    = r.port_number;
		req_ch.channel_number = r.channel_number;
		req_ch.note_number    = r.note_number;
		req_ch.now_ms         = r.now_ms;
		req_ch.valid          = 1'b1;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.log_request(r);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_fields(req_code_t code, logic [7:0] port, logic [3:0] chan,
			logic [6:0] note, time_t ms);
		req_t r;
		r.req_type       = code;
		r.port_number    = port;
		r.channel_number = chan;
		r.note_number    = note;
		r.now_ms         = ms;
		send_request(r);
	endtask

	// Stop offering and wait until every predicted beat has been checked.
	task automatic drain();
		req_ch.valid = 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// hold_duration write; only called with the block idle
	task automatic write_hold(time_t v);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
		sb.hold_ms  = v;
	endtask

	// Time mostly creeps forward; sometimes it stands still (start-time ties),
	// jumps past the hold, leaps anywhere, or reads zero.
	function automatic time_t next_ms();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return '0;
		else if (roll < 10)
			;
		else if (roll < 55)
			clock_ms += $urandom_range(0, 20);
		else if (roll < 83)
			clock_ms += $urandom_range(0, 400);
		else if (roll < 98)
			clock_ms += $urandom_range(500, 2500);
		else
			clock_ms = $urandom;
		return clock_ms;
	endfunction

	// Keys come mostly from a small hot set so note-offs and channel-offs
	// find their targets; a few use the full field ranges.
	function automatic req_t hot_key();
		req_t r;
		r = '0;
		r.port_number    = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
			8'($urandom_range(0, 1));
		r.channel_number = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) :
			4'($urandom_range(0, 2));
		r.note_number    = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127)) :
			7'($urandom_range(60, 63));
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int   roll;
		int   s;
		key_t k;
		r    = hot_key();
		roll = $urandom_range(0, 99);
		if (roll < 45)      r.req_type = REQ_NOTE_ON;
		else if (roll < 75) r.req_type = REQ_NOTE_OFF;
		else if (roll < 79) r.req_type = REQ_ALL_OFF;
		else if (roll < 86) r.req_type = REQ_CHAN_OFF;
		else if (roll < 94) r.req_type = REQ_EXPIRE;
		else if (roll < 97) r.req_type = REQ_CLEAR;
		else if (roll < 99) r.req_type = REQ_SPARE_A;
		else                r.req_type = REQ_SPARE_B;
		// aim most note-offs and channel-offs at a note that is in the table
		if ((r.req_type == REQ_NOTE_OFF || r.req_type == REQ_CHAN_OFF) &&
				$urandom_range(0, 9) < 7) begin
			s = $urandom_range(0, SLOT_COUNT - 1);
			if (sb.live[s]) begin
				k                = sb.slot_key[s];
				r.port_number    = k[KEY_W-1 -: 8];
				r.channel_number = k[NOTE_W +: 4];
				r.note_number    = k[NOTE_W-1:0];
			end
		end
		r.now_ms = next_ms();
		return r;
	endfunction

	// A run of close-together note-ons, enough to fill the table and force
	// steals unless released notes have expired.
	task automatic fill_table(output int n);
		req_t r;
		n = $urandom_range(66, 80);
		for (int i = 0; i < n; i++) begin
			r          = hot_key();
			r.req_type = REQ_NOTE_ON;
			clock_ms  += $urandom_range(0, 3);
			r.now_ms   = clock_ms;
			send_request(r);
		end
	endtask

	task automatic run_phase(int n_items, bit with_hold_off);
		int done;
		int n;
		done = 0;
		if (with_hold_off) begin
			// receiver goes dark while the sender keeps pushing, so the
			// output register and the request side back up
			ask_hold = 1'b1;
			eager    = 1'b1;
			for (int i = 0; i < 20; i++)
				send_request(random_request());
			eager = 1'b0;
			done  = 20;
		end
		while (done < n_items) begin
			if ($urandom_range(0, 59) == 0) begin
				fill_table(n);
				done += n;
			end else begin
				send_request(random_request());
				done++;
			end
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		cfg_wr_en             = 1'b0;
		cfg_wr_data           = '0;
		req_ch.valid          = 1'b0;
		req_ch.req_type       = REQ_NOTE_ON;
		req_ch.port_number    = '0;
		req_ch.channel_number = '0;
		req_ch.note_number    = '0;
		req_ch.now_ms         = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_hold(HOLD_RESET);

		// Directed: empty table, misses, release at time zero, reuse of an
		// expired slot, sweep boundary, spare codes and wrap of the clock.
		send_fields(REQ_CLEAR,    8'd0,   4'd0,  7'd0,   32'd5000);
		send_fields(REQ_NOTE_OFF, 8'd3,   4'd2,  7'd1,   32'd5000);
		send_fields(REQ_NOTE_ON,  8'd255, 4'd15, 7'd127, 32'hFFFF_FFFF);
		send_fields(REQ_NOTE_ON,  8'd0,   4'd0,  7'd0,   32'd0);
		send_fields(REQ_NOTE_OFF, 8'd0,   4'd0,  7'd0,   32'd0);   // stamps zero, still sounds
		send_fields(REQ_NOTE_OFF, 8'd0,   4'd0,  7'd0,   32'd10);  // same note matches again
		send_fields(REQ_NOTE_ON,  8'd7,   4'd3,  7'd60,  32'd20);
		send_fields(REQ_NOTE_ON,  8'd7,   4'd4,  7'd61,  32'd30);
		send_fields(REQ_CHAN_OFF, 8'd7,   4'd3,  7'd0,   32'd40);
		send_fields(REQ_NOTE_ON,  8'd9,   4'd1,  7'd64,  32'd50);
		send_fields(REQ_NOTE_ON,  8'd9,   4'd1,  7'd64,  32'd2000); // takes expired slot
		send_fields(REQ_EXPIRE,   8'd0,   4'd0,  7'd0,   32'd2100);
		send_fields(REQ_ALL_OFF,  8'd0,   4'd0,  7'd0,   32'd2200);
		send_fields(REQ_NOTE_OFF, 8'd9,   4'd1,  7'd64,  32'd2300); // already released
		send_fields(REQ_EXPIRE,   8'd0,   4'd0,  7'd0,   32'd3200); // age equals hold
		send_fields(REQ_EXPIRE,   8'd0,   4'd0,  7'd0,   32'd3201); // one past hold
		send_fields(REQ_SPARE_A,  8'd255, 4'd15, 7'd127, 32'hFFFF_FFFF);
		send_fields(REQ_SPARE_B,  8'd1,   4'd1,  7'd1,   32'd1);
		send_fields(REQ_NOTE_ON,  8'd1,   4'd1,  7'd1,   32'd100);
		send_fields(REQ_NOTE_ON,  8'd1,   4'd1,  7'd1,   32'd100);
		send_fields(REQ_CLEAR,    8'd0,   4'd0,  7'd0,   32'd0);
		send_fields(REQ_NOTE_ON,  8'd255, 4'd15, 7'd127, 32'hFFFF_FFF0);
		send_fields(REQ_NOTE_OFF, 8'd255, 4'd15, 7'd127, 32'hFFFF_FFF8);
		send_fields(REQ_NOTE_ON,  8'd2,   4'd5,  7'd9,   32'h0000_0400); // expiry across wrap
		drain();

		// Random phases under a spread of hold settings, extremes included.
		clock_ms = 32'd10_000;
		write_hold('0);
		run_phase(PHASE_ITEMS, 1'b0);
		drain();

		clock_ms = 32'hFFFF_F000;
		write_hold(32'hFFFF_FFFF);
		run_phase(PHASE_ITEMS, 1'b1);
		drain();

		write_hold(32'd50);
		run_phase(PHASE_ITEMS, 1'b0);
		drain();

		write_hold(HOLD_RESET);
		run_phase(PHASE_ITEMS, 1'b0);
		drain();

		write_hold(time_t'($urandom_range(100, 5000)));
		run_phase(PHASE_ITEMS, 1'b0);
		drain();

		// give a stray extra beat time to show up
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.finish_check();

		$display("Sent %0d requests, checked %0d result beats across six hold settings.",
			items_sent, sb.beats_checked);
		$display("Seen: %0d steals, %0d expired-slot reuses, %0d note-off matches, %0d swept.",
			sb.steals, sb.reuses, sb.off_hits, sb.swept);
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("Some tests failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("Timeout with %0d result beats outstanding", sb.expected_q.size());
		$display("Some tests failed");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/lnsa_pkg.sv
hw/rtl/lnsa_req_if.sv
hw/rtl/lnsa_rsp_if.sv
hw/rtl/lnsa_slot_mem.sv
hw/rtl/lnsa_ctrl.sv
hw/rtl/live_note_slot_allocator_top.sv
test/tb_top.sv
